>>> rtl/core/stack_machine_step_macros.svh
// Assertion macros for the stack machine core.
`ifndef STACK_MACHINE_STEP_MACROS_SVH
`define STACK_MACHINE_STEP_MACROS_SVH
`ifndef SYNTH
`define SMS_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SMS_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SMS_ASSERT_IMP(label, clk, rst_n, a, c)
`define SMS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Shared types and constants of the stack machine core.
// ----------------------------------------------------------------------------
package sms_pkg;
  localparam int unsigned ProgDepth = 1024;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned PaW = $clog2(ProgDepth);
  localparam int unsigned SaW = $clog2(StackDepth);
  localparam int unsigned PlW = PaW + 1;
  localparam int unsigned SpW = SaW + 1;
  localparam int unsigned ProgW = 37;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_EXEC = 2'd1;
  localparam logic [1:0] MODE_CLR = 2'd2;
  localparam logic [1:0] MODE_CLRALL = 2'd3;

  localparam logic [4:0] OP_PUSH = 5'd0;
  localparam logic [4:0] OP_POP = 5'd1;
  localparam logic [4:0] OP_SWAP = 5'd2;
  localparam logic [4:0] OP_ADD = 5'd3;
  localparam logic [4:0] OP_SUB = 5'd4;
  localparam logic [4:0] OP_MUL = 5'd5;
  localparam logic [4:0] OP_DIV = 5'd6;
  localparam logic [4:0] OP_RET = 5'd7;
  localparam logic [4:0] OP_JMP = 5'd8;
  localparam logic [4:0] OP_CALL = 5'd9;
  localparam logic [4:0] OP_FRET = 5'd10;
  localparam logic [4:0] OP_JEQ = 5'd11;
  localparam logic [4:0] OP_JNE = 5'd12;
  localparam logic [4:0] OP_JGT = 5'd13;
  localparam logic [4:0] OP_JGE = 5'd14;
  localparam logic [4:0] OP_JLS = 5'd15;
  localparam logic [4:0] OP_JLE = 5'd16;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_SEGV = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_DIVZERO = 3'd5;
  localparam logic [2:0] ST_PARAMS = 3'd6;
  localparam logic [2:0] ST_PROGFULL = 3'd7;

  // Datapath commands.
  typedef enum logic [4:0] {
    C_NONE, C_PROG_WR, C_PROG_RD, C_SRD, C_SPOP_X, C_SPOP_Y, C_SPOP_Z,
    C_SWR, C_DIV_START, C_MUL, C_SHIFT_RD, C_SHIFT_WR, C_SETPC, C_CLEAR,
    C_ARG_Z, C_ADD, C_SUB
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic [1:0] wsel;   // 0 x, 1 y, 2 z, 3 return address
    logic [2:0] pcsel;  // pc source: 0 keep,1 next,2 x,3 y,4 z
    logic sp_inc;
    logic sp_dec;
    logic clr_len;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [4:0] op;
    logic [31:0] arg;
    logic [31:0] pc;
    logic [PlW-1:0] len;
    logic [SpW-1:0] sp;
    logic [SpW-1:0] cnt;
  } sts_t;
endpackage

>>> rtl/core/stack_machine_step.sv
// ----------------------------------------------------------------------------
// stack_machine_step
// Stack processor core: loads program words and executes single steps.
// ----------------------------------------------------------------------------
// One word in gives one result word out. An instruction's time is set by the
// single stack RAM port, which serves one pop at a time; a divide also waits
// for the bit-serial divider, and a CALL for each argument that it moves. One
// word is in work at a time, and a new word is accepted only once the result
// word has been taken.
module stack_machine_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i, // mode[1:0], opcode[6:2], argument[38:7]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o  // status, running, returned_value,
                                      // program_counter, stack_depth
);
  import sms_pkg::*;
`include "stack_machine_step_macros.svh"

  ctl_t ctl;
  sts_t sts;
  logic busy_q, ov_q, start_q, done, halted, start;
  logic [1:0] mode_q;
  logic [4:0] lop_q;
  logic [31:0] larg_q;
  logic [2:0] st;
  logic [79:0] res_q;

  assign s_axis_tready_o = !busy_q && !ov_q;
  assign start = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (start) begin
      mode_q <= s_axis_tdata_i[1:0];
      lop_q <= s_axis_tdata_i[6:2];
      larg_q <= s_axis_tdata_i[38:7];
    end
  end

  sms_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start_q), .mode_i(mode_q),
    .sts_i(sts), .ctl_o(ctl), .done_o(done), .status_o(st), .halted_o(halted)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ov_q <= 1'b0; start_q <= 1'b0;
    end else begin
      start_q <= start;
      if (start) busy_q <= 1'b1;
      if (done) begin
        busy_q <= 1'b0; ov_q <= 1'b1;
      end else if (ov_q && m_axis_tready_i) ov_q <= 1'b0;
    end
  end

  sms_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .ld_op_i(lop_q), .ld_arg_i(larg_q), .sts_o(sts)
  );

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= {3'b0, sts.sp, sts.pc,
                (st == ST_OK && halted) ? sts.x : 32'd0,
                (st == ST_OK && !halted), st};
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = res_q;

  `SMS_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy_q, !s_axis_tready_o)
  `SMS_ASSERT_NXT(a_done_valid, clk_i, rst_ni, done, m_axis_tvalid_o)
  `SMS_ASSERT_IMP(a_sp_range, clk_i, rst_ni, 1'b1, sts.sp <= SpW'(StackDepth))
endmodule

>>> rtl/core/sms_ram.sv
// ----------------------------------------------------------------------------
// sms_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/sms_datapath.sv
// ----------------------------------------------------------------------------
// sms_datapath
// Program store, operand stack, registers, multiplier and serial divider.
// ----------------------------------------------------------------------------
module sms_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sms_pkg::ctl_t ctl_i,
  input  logic [4:0]    ld_op_i,
  input  logic [31:0]   ld_arg_i,
  output sms_pkg::sts_t sts_o
);
  import sms_pkg::*;

  logic [PlW-1:0] len_q, len_d;
  logic [SpW-1:0] sp_q, sp_d, cnt_q, cnt_d;
  logic [31:0] pc_q, pc_d, x_q, x_d, y_q, y_d, z_q, z_d;
  logic [ProgW-1:0] prog_rd;
  logic [31:0] stk_rd;
  logic pwe, swe;
  logic [PaW-1:0] paddr;
  logic [SaW-1:0] saddr;
  logic [31:0] swdata;
  // Divider state: remainder, quotient, divisor, step count, result sign.
  logic [31:0] dq_q, dq_d, dr_q, dr_d, dd_q, dd_d;
  logic [5:0] dn_q, dn_d;
  logic dneg_q, dneg_d, dbusy_q, dbusy_d;
  logic [32:0] dtrial;
  logic [31:0] next_pc;

  assign next_pc = pc_q + 32'd1;
  assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};

  sms_ram #(.Width(ProgW), .Depth(ProgDepth)) u_prog (
    .clk_i, .we_i(pwe), .addr_i(paddr), .wdata_i({ld_arg_i, ld_op_i}), .rdata_o(prog_rd)
  );
  sms_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(swe), .addr_i(saddr), .wdata_i(swdata), .rdata_o(stk_rd)
  );

  always_comb begin
    len_d = len_q; sp_d = sp_q; pc_d = pc_q; cnt_d = cnt_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    dq_d = dq_q; dr_d = dr_q; dd_d = dd_q; dn_d = dn_q; dneg_d = dneg_q;
    dbusy_d = dbusy_q;
    pwe = 1'b0; swe = 1'b0;
    paddr = len_q[PaW-1:0];
    // Idle cycles keep reading the entry just popped, so its word stays on
    // the read port until it is loaded.
    saddr = sp_q[SaW-1:0];
    unique case (ctl_i.wsel)
      2'd0: swdata = x_q;
      2'd1: swdata = y_q;
      2'd2: swdata = z_q;
      default: swdata = next_pc;
    endcase
    unique case (ctl_i.cmd)
      C_PROG_WR: begin
        pwe = 1'b1;
        len_d = len_q + PlW'(1);
      end
      C_PROG_RD: paddr = pc_q[PaW-1:0];
      C_ARG_Z: z_d = prog_rd[36:5];
      C_SRD: saddr = sp_q[SaW-1:0] - SaW'(1);
      C_SPOP_X: x_d = stk_rd;
      C_SPOP_Y: y_d = stk_rd;
      C_SPOP_Z: z_d = stk_rd;
      C_SWR: begin
        swe = 1'b1;
        saddr = sp_q[SaW-1:0];
        if (ctl_i.sp_dec) saddr = sp_q[SaW-1:0] - SaW'(1);
      end
      C_ADD: z_d = y_q + x_q;
      C_SUB: z_d = y_q - x_q;
      C_MUL: z_d = y_q * x_q;
      C_DIV_START: begin
        dq_d = y_q[31] ? -y_q : y_q;
        dd_d = x_q[31] ? -x_q : x_q;
        dr_d = '0;
        dn_d = 6'd32;
        dneg_d = y_q[31] ^ x_q[31];
        dbusy_d = 1'b1;
      end
      C_SHIFT_RD: begin
        // Read entry cnt-1, the one just below slot cnt, for moving up by one.
        saddr = cnt_q[SaW-1:0] - SaW'(1);
      end
      C_SHIFT_WR: begin
        swe = 1'b1;
        saddr = cnt_q[SaW-1:0];
        cnt_d = cnt_q - SpW'(1);
      end
      C_SETPC: cnt_d = sp_q;
      C_CLEAR: begin
        sp_d = '0;
        pc_d = '0;
        if (ctl_i.clr_len) len_d = '0;
      end
      default: ;
    endcase
    // In shift writes, the word moved comes from the read data.
    if (ctl_i.cmd == C_SHIFT_WR) swdata = stk_rd;
    if (ctl_i.cmd == C_SWR && ctl_i.wsel == 2'd3 && ctl_i.sp_dec) begin
      saddr = cnt_q[SaW-1:0];
    end
    if (ctl_i.sp_inc) sp_d = sp_q + SpW'(1);
    if (ctl_i.sp_dec && ctl_i.cmd != C_SWR) sp_d = sp_q - SpW'(1);
    unique case (ctl_i.pcsel)
      3'd1: pc_d = next_pc;
      3'd2: pc_d = x_q;
      3'd3: pc_d = y_q;
      3'd4: pc_d = z_q;
      default: ;
    endcase
    if (dbusy_q) begin
      dq_d = {dq_q[30:0], ~dtrial[32]};
      dr_d = dtrial[32] ? {dr_q[30:0], dq_q[31]} : dtrial[31:0];
      dn_d = dn_q - 6'd1;
      if (dn_q == 6'd1) dbusy_d = 1'b0;
    end
    if (dbusy_q && dn_q == 6'd1) begin
      z_d = dneg_q ? -{dq_q[30:0], ~dtrial[32]} : {dq_q[30:0], ~dtrial[32]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; sp_q <= '0; pc_q <= '0; dbusy_q <= 1'b0; dn_q <= '0;
    end else begin
      len_q <= len_d; sp_q <= sp_d; pc_q <= pc_d; dbusy_q <= dbusy_d; dn_q <= dn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; cnt_q <= cnt_d;
    dq_q <= dq_d; dr_q <= dr_d; dd_q <= dd_d; dneg_q <= dneg_d;
  end

  assign sts_o.div_done = dbusy_q && dn_q == 6'd1;
  assign sts_o.x = x_q;
  assign sts_o.y = y_q;
  assign sts_o.z = z_q;
  assign sts_o.op = prog_rd[4:0];
  assign sts_o.arg = prog_rd[36:5];
  assign sts_o.pc = pc_q;
  assign sts_o.len = len_q;
  assign sts_o.sp = sp_q;
  assign sts_o.cnt = cnt_q;
endmodule

>>> rtl/core/sms_ctrl.sv
// ----------------------------------------------------------------------------
// sms_ctrl
// Sequencer that steps each instruction through the datapath.
// ----------------------------------------------------------------------------
module sms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    mode_i,
  input  sms_pkg::sts_t sts_i,
  output sms_pkg::ctl_t ctl_o,
  output logic          done_o,
  output logic [2:0]    status_o,
  output logic          halted_o
);
  import sms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DEC, S_POPRD, S_POPWT, S_POPLD, S_DIVW, S_WR,
    S_SHRD, S_SHWT, S_SHWR, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [4:0] op_q, op_d;
  logic [31:0] arg_q, arg_d;
  logic [1:0] npop_q, npop_d, pidx_q, pidx_d;
  logic [2:0] st_q, st_d;
  logic halt_q, halt_d;
  logic [SpW-1:0] stop_q, stop_d;
  ctl_t c;
  logic cmp;

  always_comb begin
    unique case (op_q)
      OP_JEQ: cmp = sts_i.y == sts_i.x;
      OP_JNE: cmp = sts_i.y != sts_i.x;
      OP_JGT: cmp = $signed(sts_i.y) > $signed(sts_i.x);
      OP_JGE: cmp = $signed(sts_i.y) >= $signed(sts_i.x);
      OP_JLS: cmp = $signed(sts_i.y) < $signed(sts_i.x);
      default: cmp = $signed(sts_i.y) <= $signed(sts_i.x);
    endcase
  end

  always_comb begin
    state_d = state_q; op_d = op_q; arg_d = arg_q;
    npop_d = npop_q; pidx_d = pidx_q; st_d = st_q; halt_d = halt_q;
    stop_d = stop_q;
    c = '{cmd: C_NONE, wsel: 2'd0, pcsel: 3'd0, sp_inc: 1'b0, sp_dec: 1'b0,
          clr_len: 1'b0};
    unique case (state_q)
      S_IDLE: if (start_i) begin
        st_d = ST_OK; halt_d = 1'b0;
        unique case (mode_i)
          MODE_LOAD: begin
            if (sts_i.len >= PlW'(ProgDepth)) st_d = ST_PROGFULL;
            else c.cmd = C_PROG_WR;
            state_d = S_DONE;
          end
          MODE_EXEC: begin
            if (sts_i.pc >= 32'(sts_i.len)) begin
              st_d = ST_SEGV; state_d = S_DONE;
            end else begin
              c.cmd = C_PROG_RD; state_d = S_FETCH;
            end
          end
          default: begin
            c.cmd = C_CLEAR; c.clr_len = (mode_i == MODE_CLRALL);
            state_d = S_DONE;
          end
        endcase
      end
      S_FETCH: begin
        // The push value goes to z while the program word is on the read port.
        c.cmd = C_ARG_Z;
        op_d = sts_i.op; arg_d = sts_i.arg; state_d = S_DEC;
      end
      S_DEC: begin
        pidx_d = 2'd0;
        state_d = S_POPRD;
        unique case (op_q)
          OP_PUSH: begin
            if (sts_i.sp >= SpW'(StackDepth)) begin
              st_d = ST_FULL; state_d = S_DONE;
            end else state_d = S_WR;
          end
          OP_POP, OP_RET, OP_JMP, OP_CALL: npop_d = 2'd1;
          OP_SWAP: begin
            if (sts_i.sp < SpW'(2)) begin
              st_d = ST_EMPTY; state_d = S_DONE;
            end else npop_d = 2'd2;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_FRET: npop_d = 2'd2;
          OP_JEQ, OP_JNE, OP_JGT, OP_JGE, OP_JLS, OP_JLE: npop_d = 2'd3;
          default: begin
            st_d = ST_UNKNOWN; state_d = S_DONE;
          end
        endcase
      end
      S_POPRD: begin
        if (sts_i.sp == '0) begin
          st_d = ST_EMPTY; state_d = S_DONE;
        end else begin
          c.cmd = C_SRD; c.sp_dec = 1'b1; state_d = S_POPWT;
        end
      end
      S_POPWT: state_d = S_POPLD;
      S_POPLD: begin
        // Compare jumps pop the address into z, then b into x, then a into y.
        if (npop_q == 2'd3) begin
          c.cmd = (pidx_q == 2'd0) ? C_SPOP_Z : (pidx_q == 2'd1) ? C_SPOP_X : C_SPOP_Y;
        end else begin
          c.cmd = (pidx_q == 2'd0) ? C_SPOP_X : C_SPOP_Y;
        end
        pidx_d = pidx_q + 2'd1;
        state_d = S_WR;
        if (pidx_q + 2'd1 != npop_q) state_d = S_POPRD;
        if (op_q == OP_DIV) state_d = S_DIVW;
      end
      S_DIVW: begin
        // First pop landed in x: check divisor, then continue.
        if (pidx_q == 2'd1) begin
          if (sts_i.x == '0) begin
            st_d = ST_DIVZERO; state_d = S_DONE;
          end else state_d = S_POPRD;
        end else if (pidx_q == 2'd2) begin
          c.cmd = C_DIV_START; pidx_d = 2'd3;
        end else if (sts_i.div_done) begin
          state_d = S_WR;
        end
      end
      S_WR: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_PUSH: begin
            c.cmd = C_SWR; c.wsel = 2'd2; c.sp_inc = 1'b1; c.pcsel = 3'd1;
          end
          OP_POP: c.pcsel = 3'd1;
          OP_SWAP: begin
            if (pidx_q == 2'd2) begin
              c.cmd = C_SWR; c.wsel = 2'd0; c.sp_inc = 1'b1; pidx_d = 2'd3;
              state_d = S_WR;
            end else begin
              c.cmd = C_SWR; c.wsel = 2'd1; c.sp_inc = 1'b1; c.pcsel = 3'd1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            if (pidx_q == 2'd2) begin
              c.cmd = (op_q == OP_ADD) ? C_ADD : (op_q == OP_SUB) ? C_SUB : C_MUL;
              pidx_d = 2'd3; state_d = S_WR;
            end else begin
              c.cmd = C_SWR; c.wsel = 2'd2; c.sp_inc = 1'b1; c.pcsel = 3'd1;
            end
          end
          OP_DIV: begin
            c.cmd = C_SWR; c.wsel = 2'd2; c.sp_inc = 1'b1; c.pcsel = 3'd1;
          end
          OP_RET: halt_d = 1'b1;
          OP_JMP: c.pcsel = 3'd2;
          OP_FRET: begin
            c.cmd = C_SWR; c.wsel = 2'd0; c.sp_inc = 1'b1; c.pcsel = 3'd3;
          end
          OP_CALL: begin
            if (32'(sts_i.sp) < arg_q) begin
              st_d = ST_PARAMS;
            end else begin
              c.cmd = C_SETPC;
              stop_d = sts_i.sp - SpW'(arg_q);
              state_d = S_SHRD;
            end
          end
          default: c.pcsel = cmp ? 3'd4 : 3'd1;
        endcase
      end
      S_SHRD: begin
        if (sts_i.cnt == stop_q) begin
          // Insert the return address at the vacated slot.
          c.cmd = C_SWR; c.wsel = 2'd3; c.sp_dec = 1'b1; c.sp_inc = 1'b1;
          if (sts_i.sp + SpW'(1) >= SpW'(StackDepth)) st_d = ST_FULL;
          else c.pcsel = 3'd2;
          state_d = S_DONE;
        end else begin
          c.cmd = C_SHIFT_RD; state_d = S_SHWT;
        end
      end
      S_SHWT: begin
        c.cmd = C_SHIFT_RD; state_d = S_SHWR;
      end
      S_SHWR: begin
        c.cmd = C_SHIFT_WR; state_d = S_SHRD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; op_q <= '0; arg_q <= '0; npop_q <= '0;
      pidx_q <= '0; st_q <= ST_OK; halt_q <= 1'b0; stop_q <= '0;
    end else begin
      state_q <= state_d; op_q <= op_d; arg_q <= arg_d;
      npop_q <= npop_d; pidx_q <= pidx_d; st_q <= st_d; halt_q <= halt_d;
      stop_q <= stop_d;
    end
  end

  assign ctl_o = c;
  assign done_o = state_q == S_DONE;
  assign status_o = st_q;
  assign halted_o = halt_q;
endmodule
